FILE: design/nfci_pkg.sv
// Package: types, constants and codes of the NOR flash command interface unit.
package nfci_pkg;
   localparam int BUFFER_WORDS = 32;
   localparam int BUF_IDX_BITS = 5;
   localparam int SECTOR_BITS = 16;
   localparam int ADDRESS_BITS = 24;

   localparam logic [1:0] OP_READ = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   localparam logic [1:0] KIND_READ = 2'd0;
   localparam logic [1:0] KIND_PROGRAM = 2'd1;
   localparam logic [1:0] KIND_ERASE = 2'd2;
   localparam logic [1:0] KIND_ABORT = 2'd3;

   localparam logic [2:0] CSR_PROGRAM_TICKS = 3'd0;
   localparam logic [2:0] CSR_ERASE_TICKS = 3'd1;
   localparam logic [2:0] CSR_MAKER = 3'd2;
   localparam logic [2:0] CSR_DEV_ONE = 3'd3;
   localparam logic [2:0] CSR_DEV_TWO = 3'd4;
   localparam logic [2:0] CSR_DEV_THREE = 3'd5;

   typedef struct packed {
      logic [1:0] operation;
      logic [23:0] word_address;
      logic [15:0] write_word;
      logic [15:0] array_word;
   } req_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [15:0] read_word;
      logic [23:0] target_address;
      logic [15:0] program_word;
      logic last_of_run;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;      // latch the input item
      logic do_read;      // form a read result
      logic do_tick;      // count busy down
      logic set_sector;   // latch load sector base
      logic set_count;    // latch words expected, clear loaded
      logic store_word;   // write buffer entry
      logic start_drain;  // reset drain index
      logic drain_step;   // emit buffer entry, advance
      logic emit_abort;
      logic emit_erase;
      logic busy_program;
      logic busy_erase;
      logic set_auto;
      logic clr_auto;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic busy;
      logic [1:0] operation;
      logic [7:0] cmd;
      logic low_555;
      logic low_2aa;
      logic sector_match;
      logic page_match;
      logic count_ok;
      logic first_word;
      logic full;         // loaded reaches expected after this store
      logic room;         // loaded below expected and buffer size
      logic drain_last;
      logic out_full;
   } sts_type;
endpackage

FILE: design/nfci_datapath.sv
// Datapath: registers, command buffer, busy counter and result register.
module nfci_datapath (
   input logic clock,
   input logic reset,
   input logic csr_write,
   input logic [2:0] csr_index,
   input logic [23:0] csr_data,
   input nfci_pkg::req_type req_item,
   input nfci_pkg::cmd_type cmd,
   output nfci_pkg::sts_type sts,
   output logic rsp_valid,
   input logic rsp_stall,
   output nfci_pkg::rsp_type rsp_item
);
   import nfci_pkg::*;

   logic [15:0] prog_ticks_ff;
   logic [23:0] erase_ticks_ff;
   logic [15:0] maker_ff, dev1_ff, dev2_ff, dev3_ff;
   req_type item_ff;
   logic [23:0] sector_ff, page_ff, busy_ff;
   logic [5:0] expected_ff, loaded_ff, drain_ff;
   logic toggle_ff, auto_ff, out_valid_ff;
   rsp_type out_ff, out_in;
   logic [15:0] buf_word [BUFFER_WORDS];
   logic [BUF_IDX_BITS-1:0] buf_off [BUFFER_WORDS];
   logic [15:0] rd_word_ff;
   logic [BUF_IDX_BITS-1:0] rd_off_ff;
   logic [23:0] sector_cur, page_cur;
   logic [15:0] auto_word;

   assign sector_cur = {item_ff.word_address[23:SECTOR_BITS], {SECTOR_BITS{1'b0}}};
   assign page_cur = {item_ff.word_address[23:BUF_IDX_BITS], {BUF_IDX_BITS{1'b0}}};

   // status toward the controller
   always_comb begin
      sts.busy = busy_ff != 24'd0;
      sts.operation = item_ff.operation;
      sts.cmd = item_ff.write_word[7:0];
      sts.low_555 = item_ff.word_address[10:0] == 11'h555;
      sts.low_2aa = item_ff.word_address[10:0] == 11'h2aa;
      sts.sector_match = sector_cur == sector_ff;
      sts.page_match = page_cur == page_ff;
      sts.count_ok = item_ff.write_word < 16'(BUFFER_WORDS);
      sts.first_word = loaded_ff == 6'd0;
      sts.full = (loaded_ff + 6'd1) >= expected_ff;
      sts.room = loaded_ff < expected_ff && loaded_ff < 6'(BUFFER_WORDS);
      sts.drain_last = (drain_ff + 6'd1) >= loaded_ff;
      sts.out_full = out_valid_ff;
   end

   always_comb begin
      case (item_ff.word_address[7:0])
         8'h00: auto_word = maker_ff;
         8'h01: auto_word = dev1_ff;
         8'h0e: auto_word = dev2_ff;
         8'h0f: auto_word = dev3_ff;
         default: auto_word = 16'd0;
      endcase
   end

   // next result item
   always_comb begin
      out_in = '0;
      out_in.last_of_run = 1'b1;
      if (cmd.drain_step) begin
         out_in.result_kind = KIND_PROGRAM;
         out_in.target_address = page_ff + {19'd0, rd_off_ff};
         out_in.program_word = rd_word_ff;
         out_in.last_of_run = sts.drain_last;
      end else if (cmd.emit_abort) begin
         out_in.result_kind = KIND_ABORT;
         out_in.target_address = sector_ff;
      end else if (cmd.emit_erase) begin
         out_in.result_kind = KIND_ERASE;
         out_in.target_address = sector_cur;
      end else begin
         out_in.result_kind = KIND_READ;
         if (busy_ff != 24'd0) out_in.read_word = {9'd0, toggle_ff, 6'd0};
         else if (auto_ff) out_in.read_word = auto_word;
         else out_in.read_word = item_ff.array_word;
      end
   end

   // buffer memory, registered read at drain index
   always_ff @(posedge clock) begin
      if (cmd.store_word) begin
         buf_word[loaded_ff[BUF_IDX_BITS-1:0]] <= item_ff.write_word;
         buf_off[loaded_ff[BUF_IDX_BITS-1:0]] <= item_ff.word_address[BUF_IDX_BITS-1:0];
      end
      rd_word_ff <= buf_word[drain_ff[BUF_IDX_BITS-1:0]];
      rd_off_ff <= buf_off[drain_ff[BUF_IDX_BITS-1:0]];
   end

   // configuration, state and result register
   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= req_item;
      if (reset) begin
         prog_ticks_ff <= 16'd100;
         erase_ticks_ff <= 24'd50000;
         maker_ff <= 16'd1;
         dev1_ff <= 16'd8830;
         dev2_ff <= 16'd8738;
         dev3_ff <= 16'd8705;
         sector_ff <= '0;
         page_ff <= '0;
         busy_ff <= '0;
         expected_ff <= '0;
         loaded_ff <= '0;
         drain_ff <= '0;
         toggle_ff <= 1'b0;
         auto_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_PROGRAM_TICKS: prog_ticks_ff <= csr_data[15:0];
               CSR_ERASE_TICKS: erase_ticks_ff <= csr_data;
               CSR_MAKER: maker_ff <= csr_data[15:0];
               CSR_DEV_ONE: dev1_ff <= csr_data[15:0];
               CSR_DEV_TWO: dev2_ff <= csr_data[15:0];
               CSR_DEV_THREE: dev3_ff <= csr_data[15:0];
               default: ;
            endcase
         end
         if (cmd.do_tick && busy_ff != 24'd0) busy_ff <= busy_ff - 24'd1;
         if (cmd.busy_program) busy_ff <= {8'd0, prog_ticks_ff};
         if (cmd.busy_erase) busy_ff <= erase_ticks_ff;
         if (cmd.set_auto) auto_ff <= 1'b1;
         if (cmd.clr_auto) auto_ff <= 1'b0;
         if (cmd.set_sector) sector_ff <= sector_cur;
         if (cmd.set_count) begin
            expected_ff <= item_ff.write_word[5:0] + 6'd1;
            loaded_ff <= '0;
         end
         if (cmd.store_word) begin
            loaded_ff <= loaded_ff + 6'd1;
            if (loaded_ff == 6'd0) page_ff <= page_cur;
         end
         if (cmd.start_drain) drain_ff <= '0;
         if (cmd.drain_step) drain_ff <= drain_ff + 6'd1;
         // status reads flip the toggle bit
         if (cmd.do_read && busy_ff != 24'd0) toggle_ff <= ~toggle_ff;
         if (cmd.do_read || cmd.emit_abort || cmd.emit_erase || cmd.drain_step) begin
            out_valid_ff <= 1'b1;
            out_ff <= out_in;
         end else if (out_valid_ff && !rsp_stall) out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item = out_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> out_valid_ff)
      else $error("pending result lost");
   a_loaded_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= 6'(BUFFER_WORDS))
      else $error("buffer count overflow");
   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.do_read, cmd.emit_abort, cmd.emit_erase, cmd.drain_step}) <= 1)
      else $error("two results at once");
`endif
endmodule

FILE: design/nfci_controller.sv
// Controller: command sequence state machine and result sequencing.
module nfci_controller (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input nfci_pkg::sts_type sts,
   output nfci_pkg::cmd_type cmd
);
   import nfci_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_UNLOCK1 = 4'd1;
   localparam logic [3:0] ST_UNLOCKED = 4'd2;
   localparam logic [3:0] ST_ERASE_SETUP = 4'd3;
   localparam logic [3:0] ST_ERASE_UNLOCK1 = 4'd4;
   localparam logic [3:0] ST_ERASE_UNLOCKED = 4'd5;
   localparam logic [3:0] ST_LOAD_COUNT = 4'd6;
   localparam logic [3:0] ST_LOAD_DATA = 4'd7;
   localparam logic [3:0] ST_LOAD_CONFIRM = 4'd8;

   // phase: waiting, decoding, buffer read, draining
   localparam logic [1:0] PH_WAIT = 2'd0;
   localparam logic [1:0] PH_EXEC = 2'd1;
   localparam logic [1:0] PH_FETCH = 2'd2;
   localparam logic [1:0] PH_DRAIN = 2'd3;

   logic [3:0] step_ff, step_in;
   logic [1:0] phase_ff, phase_in;

   assign req_stall = phase_ff != PH_WAIT;

   always_comb begin
      cmd = '0;
      step_in = step_ff;
      phase_in = phase_ff;
      case (phase_ff)
         PH_WAIT: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               phase_in = PH_EXEC;
            end
         end
         PH_EXEC: begin
            // hold until the result register is free
            if (!sts.out_full) begin
               phase_in = PH_WAIT;
               if (sts.operation == OP_READ) cmd.do_read = 1'b1;
               else if (sts.operation == OP_TICK) cmd.do_tick = 1'b1;
               else if (sts.operation == OP_WRITE && !sts.busy) begin
                  case (step_ff)
                     ST_LOAD_COUNT: begin
                        if (!sts.sector_match || !sts.count_ok) begin
                           cmd.emit_abort = 1'b1;
                           step_in = ST_IDLE;
                        end else begin
                           cmd.set_count = 1'b1;
                           step_in = ST_LOAD_DATA;
                        end
                     end
                     ST_LOAD_DATA: begin
                        if (!sts.sector_match || (!sts.first_word && !sts.page_match)
                            || !sts.room) begin
                           cmd.emit_abort = 1'b1;
                           step_in = ST_IDLE;
                        end else begin
                           cmd.store_word = 1'b1;
                           if (sts.full) step_in = ST_LOAD_CONFIRM;
                        end
                     end
                     ST_LOAD_CONFIRM: begin
                        step_in = ST_IDLE;
                        if (sts.cmd != 8'h29 || !sts.sector_match) cmd.emit_abort = 1'b1;
                        else begin
                           cmd.start_drain = 1'b1;
                           cmd.busy_program = 1'b1;
                           phase_in = PH_FETCH;
                        end
                     end
                     default: begin
                        if (sts.cmd == 8'hf0) begin
                           cmd.clr_auto = 1'b1;
                           step_in = ST_IDLE;
                        end else begin
                           step_in = ST_IDLE;
                           case (step_ff)
                              ST_IDLE:
                                 if (sts.low_555 && sts.cmd == 8'haa) step_in = ST_UNLOCK1;
                              ST_UNLOCK1:
                                 if (sts.low_2aa && sts.cmd == 8'h55) step_in = ST_UNLOCKED;
                              ST_UNLOCKED: begin
                                 if (sts.cmd == 8'h25) begin
                                    cmd.set_sector = 1'b1;
                                    step_in = ST_LOAD_COUNT;
                                 end else if (sts.low_555 && sts.cmd == 8'h80)
                                    step_in = ST_ERASE_SETUP;
                                 else if (sts.low_555 && sts.cmd == 8'h90)
                                    cmd.set_auto = 1'b1;
                              end
                              ST_ERASE_SETUP:
                                 if (sts.low_555 && sts.cmd == 8'haa)
                                    step_in = ST_ERASE_UNLOCK1;
                              ST_ERASE_UNLOCK1:
                                 if (sts.low_2aa && sts.cmd == 8'h55)
                                    step_in = ST_ERASE_UNLOCKED;
                              ST_ERASE_UNLOCKED:
                                 if (sts.cmd == 8'h30) begin
                                    cmd.emit_erase = 1'b1;
                                    cmd.busy_erase = 1'b1;
                                 end
                              default: step_in = ST_IDLE;
                           endcase
                        end
                     end
                  endcase
               end
            end
         end
         PH_FETCH: phase_in = PH_DRAIN;
         PH_DRAIN: begin
            if (!sts.out_full) begin
               cmd.drain_step = 1'b1;
               phase_in = sts.drain_last ? PH_WAIT : PH_FETCH;
            end
         end
         default: phase_in = PH_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
         phase_ff <= PH_WAIT;
      end else begin
         step_ff <= step_in;
         phase_ff <= phase_in;
      end
   end

`ifndef SYNTHESIS
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DRAIN || phase_ff == PH_FETCH) |-> req_stall)
      else $error("item taken during drain");
   a_fetch_next: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FETCH) |=> (phase_ff == PH_DRAIN))
      else $error("fetch not followed by drain");
   a_capture_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (phase_ff == PH_WAIT))
      else $error("capture outside wait");
`endif
endmodule

FILE: design/nor_flash_command_interface_unit.sv
// Top level of the NOR flash command interface unit.
// An accepted item is registered, then decoded to its result or state update.
// No item is taken while one is decoded or drained; buffered words drain one at a time.
// A result held by rsp_stall holds the next item's decode until the result is taken.
// Reset is synchronous, active high: read mode idle, registers to defaults.
module nor_flash_command_interface_unit (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input nfci_pkg::req_type req_item,
   output logic rsp_valid,
   input logic rsp_stall,
   output nfci_pkg::rsp_type rsp_item,
   input logic csr_write,
   input logic [2:0] csr_index,
   input logic [23:0] csr_data
);
   import nfci_pkg::*;

   cmd_type cmd;
   sts_type sts;

   nfci_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .sts(sts), .cmd(cmd)
   );

   nfci_datapath u_dp (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .req_item(req_item), .cmd(cmd), .sts(sts),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
   );
endmodule

FILE: sim/nor_flash_command_interface_unit_tb.sv
// Self-checking testbench for the NOR flash command interface unit.
`timescale 1ns / 100ps

module nor_flash_command_interface_unit_tb;
   import nfci_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 16;

   // sequencer states of the predictor
   typedef enum logic [3:0] {
      SEQ_IDLE, SEQ_UNLOCK1, SEQ_UNLOCKED, SEQ_ERASE_SETUP, SEQ_ERASE_UNLOCK1,
      SEQ_ERASE_UNLOCKED, SEQ_LOAD_COUNT, SEQ_LOAD_DATA, SEQ_LOAD_CONFIRM
   } seq_state_type;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [7:0] CMD_UNLOCK_A = 8'hAA;
   localparam logic [7:0] CMD_UNLOCK_B = 8'h55;
   localparam logic [7:0] CMD_BUF_LOAD = 8'h25;
   localparam logic [7:0] CMD_CONFIRM = 8'h29;
   localparam logic [7:0] CMD_ERASE = 8'h80;
   localparam logic [7:0] CMD_SECTOR = 8'h30;
   localparam logic [7:0] CMD_AUTOSEL = 8'h90;
   localparam logic [7:0] CMD_RESET = 8'hF0;
   localparam logic [10:0] ADDR_UNLOCK_A = 11'h555;
   localparam logic [10:0] ADDR_UNLOCK_B = 11'h2AA;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_item;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [23:0] csr_data = '0;

   nor_flash_command_interface_unit i_dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [15:0] prog_ticks;
   logic [23:0] erase_ticks;
   logic [15:0] id_words [4];
   seq_state_type seq_state;
   logic [15:0] buf_data [BUFFER_WORDS];
   logic [4:0] buf_offset [BUFFER_WORDS];
   int words_wanted, words_held;
   logic [23:0] sector_base, page_base;
   logic [23:0] busy_count;
   logic toggle;
   logic autosel;

   req_type pending_items [$];
   rsp_type expected_rsp [$];
   int error_count = 0;
   bit no_idle = 0;
   int send_gap = 0, stall_left = 0;
   int quiet_cycles = 0;

   // req_stall_seen: high while the presented item has not yet been taken
   logic req_stall_seen = 1'b0;
   logic req_taken;
   assign req_taken = req_valid && !req_stall;

   logic [7:0] id_offsets [4] = '{8'h00, 8'h01, 8'h0E, 8'h0F};

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic rsp_type make_rsp(logic [1:0] kind, logic [15:0] rd,
                                        logic [23:0] tgt, logic [15:0] pw, logic last);
      rsp_type r;
      r.result_kind = kind; r.read_word = rd; r.target_address = tgt;
      r.program_word = pw; r.last_of_run = last;
      return r;
   endfunction

   task automatic push_abort();
      seq_state = SEQ_IDLE;
      expected_rsp.push_back(make_rsp(KIND_ABORT, '0, sector_base, '0, 1'b1));
   endtask

   task automatic predict_write(logic [23:0] a, logic [15:0] d);
      logic [7:0] cmd;
      logic [10:0] low;
      logic [23:0] sect, page;
      cmd = d[7:0]; low = a[10:0]; sect = {a[23:16], 16'h0}; page = {a[23:5], 5'h0};
      case (seq_state)
         SEQ_LOAD_COUNT: begin
            if (sect != sector_base || d >= BUFFER_WORDS) push_abort();
            else begin
               words_wanted = d + 1; words_held = 0; seq_state = SEQ_LOAD_DATA;
            end
            return;
         end
         SEQ_LOAD_DATA: begin
            if (sect != sector_base) begin push_abort(); return; end
            if (words_held == 0) page_base = page;
            else if (page != page_base) begin push_abort(); return; end
            if (words_held >= BUFFER_WORDS || words_held >= words_wanted) begin
               push_abort(); return;
            end
            buf_data[words_held] = d; buf_offset[words_held] = a[4:0];
            words_held++;
            if (words_held >= words_wanted) seq_state = SEQ_LOAD_CONFIRM;
            return;
         end
         SEQ_LOAD_CONFIRM: begin
            if (cmd != CMD_CONFIRM || sect != sector_base) begin push_abort(); return; end
            for (int i = 0; i < words_held; i++)
               expected_rsp.push_back(make_rsp(KIND_PROGRAM, '0,
                  page_base + buf_offset[i], buf_data[i], i + 1 == words_held));
            busy_count = prog_ticks; seq_state = SEQ_IDLE;
            return;
         end
         default: ;
      endcase
      if (cmd == CMD_RESET) begin autosel = 0; seq_state = SEQ_IDLE; return; end
      case (seq_state)
         SEQ_IDLE: if (low == ADDR_UNLOCK_A && cmd == CMD_UNLOCK_A) seq_state = SEQ_UNLOCK1;
         SEQ_UNLOCK1: seq_state = (low == ADDR_UNLOCK_B && cmd == CMD_UNLOCK_B) ?
                                  SEQ_UNLOCKED : SEQ_IDLE;
         SEQ_UNLOCKED: begin
            seq_state = SEQ_IDLE;
            if (cmd == CMD_BUF_LOAD) begin sector_base = sect; seq_state = SEQ_LOAD_COUNT; end
            else if (low == ADDR_UNLOCK_A && cmd == CMD_ERASE) seq_state = SEQ_ERASE_SETUP;
            else if (low == ADDR_UNLOCK_A && cmd == CMD_AUTOSEL) autosel = 1;
         end
         SEQ_ERASE_SETUP: seq_state = (low == ADDR_UNLOCK_A && cmd == CMD_UNLOCK_A) ?
                                      SEQ_ERASE_UNLOCK1 : SEQ_IDLE;
         SEQ_ERASE_UNLOCK1: seq_state = (low == ADDR_UNLOCK_B && cmd == CMD_UNLOCK_B) ?
                                        SEQ_ERASE_UNLOCKED : SEQ_IDLE;
         SEQ_ERASE_UNLOCKED: begin
            seq_state = SEQ_IDLE;
            if (cmd == CMD_SECTOR) begin
               busy_count = erase_ticks;
               expected_rsp.push_back(make_rsp(KIND_ERASE, '0, sect, '0, 1'b1));
            end
         end
         default: seq_state = SEQ_IDLE;
      endcase
   endtask

   task automatic predict_item(req_type it);
      logic [15:0] rd;
      case (it.operation)
         OP_READ: begin
            if (busy_count != 0) begin rd = {9'h0, toggle, 6'h0}; toggle = ~toggle; end
            else if (autosel) begin
               case (it.word_address[7:0])
                  8'h00: rd = id_words[0];
                  8'h01: rd = id_words[1];
                  8'h0E: rd = id_words[2];
                  8'h0F: rd = id_words[3];
                  default: rd = '0;
               endcase
            end else rd = it.array_word;
            expected_rsp.push_back(make_rsp(KIND_READ, rd, '0, '0, 1'b1));
         end
         OP_WRITE: if (busy_count == 0) predict_write(it.word_address, it.write_word);
         OP_TICK: if (busy_count != 0) busy_count--;
         default: ;
      endcase
   endtask

   // driver: presents queued items, random gaps between them
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_stall_seen) begin
         // item still held
      end else begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_item <= pending_items.pop_front();
            req_valid <= 1'b1;
            if (!no_idle && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 15);
         end else begin
            req_valid <= 1'b0;
         end
      end
      // receiver stall bursts
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (!no_idle && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 15);
      end
   end

   // monitor: predicts on accepted items, checks accepted results
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset) begin
         req_stall_seen <= req_valid && req_stall;
         if (req_taken) predict_item(req_item);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) report_mismatch("result with none expected");
            else begin
               exp_r = expected_rsp.pop_front();
               if (rsp_item.result_kind !== exp_r.result_kind)
                  report_mismatch($sformatf("kind %0d exp %0d",
                     rsp_item.result_kind, exp_r.result_kind));
               if (rsp_item.read_word !== exp_r.read_word)
                  report_mismatch($sformatf("read_word %h exp %h",
                     rsp_item.read_word, exp_r.read_word));
               if (rsp_item.target_address !== exp_r.target_address)
                  report_mismatch($sformatf("target %h exp %h",
                     rsp_item.target_address, exp_r.target_address));
               if (rsp_item.program_word !== exp_r.program_word)
                  report_mismatch($sformatf("program_word %h exp %h",
                     rsp_item.program_word, exp_r.program_word));
               if (rsp_item.last_of_run !== exp_r.last_of_run)
                  report_mismatch($sformatf("last %b exp %b",
                     rsp_item.last_of_run, exp_r.last_of_run));
            end
         end
         // watchdog on any handshake
         if (req_taken || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic req_type mk(logic [1:0] op, logic [23:0] a, logic [15:0] d,
                                  logic [15:0] arr);
      req_type r;
      r.operation = op; r.word_address = a; r.write_word = d; r.array_word = arr;
      return r;
   endfunction

   function automatic logic [23:0] rnd_addr();
      return 24'($urandom);
   endfunction

   task automatic add_unlock(logic [23:0] hi);
      pending_items.push_back(mk(OP_WRITE, {hi[23:11], ADDR_UNLOCK_A}, {8'($urandom), CMD_UNLOCK_A}, 16'($urandom)));
      pending_items.push_back(mk(OP_WRITE, {hi[23:11], ADDR_UNLOCK_B}, {8'($urandom), CMD_UNLOCK_B}, 16'($urandom)));
   endtask

   task automatic add_ticks(int n);
      repeat (n) pending_items.push_back(mk(OP_TICK, rnd_addr(), 16'($urandom), 16'($urandom)));
   endtask

   task automatic add_reads(int n);
      repeat (n) pending_items.push_back(mk(OP_READ, rnd_addr(), 16'($urandom), 16'($urandom)));
   endtask

   // buffer load; flaw 0 means well formed
   task automatic add_buffer(int count, int flaw);
      logic [23:0] base, page;
      base = {8'($urandom), 16'h0};
      page = base | {8'h0, 11'($urandom), 5'h0};
      add_unlock(rnd_addr());
      pending_items.push_back(mk(OP_WRITE, base | 24'($urandom_range(0, 65535)),
         {8'($urandom), CMD_BUF_LOAD}, 16'($urandom)));
      if (flaw == 1) begin
         pending_items.push_back(mk(OP_WRITE, base, 16'($urandom_range(32, 65535)), '0));
         return;
      end
      if (flaw == 2) begin
         pending_items.push_back(mk(OP_WRITE, base ^ 24'h010000, 16'(count - 1), '0));
         return;
      end
      pending_items.push_back(mk(OP_WRITE, base | 24'($urandom_range(0, 65535)),
         16'(count - 1), 16'($urandom)));
      for (int i = 0; i < count; i++) begin
         if (flaw == 3 && i == count - 1) begin
            pending_items.push_back(mk(OP_WRITE, page ^ 24'h000020, 16'($urandom), '0));
            return;
         end
         pending_items.push_back(mk(OP_WRITE, page | 24'($urandom_range(0, 31)),
            16'($urandom), 16'($urandom)));
      end
      if (flaw == 4)
         pending_items.push_back(mk(OP_WRITE, base, {8'($urandom), CMD_SECTOR}, '0));
      else if (flaw == 5)
         pending_items.push_back(mk(OP_WRITE, base ^ 24'h800000, {8'h0, CMD_CONFIRM}, '0));
      else
         pending_items.push_back(mk(OP_WRITE, base | 24'($urandom_range(0, 65535)),
            {8'($urandom), CMD_CONFIRM}, '0));
   endtask

   task automatic add_erase(logic [7:0] last_cmd);
      add_unlock(rnd_addr());
      pending_items.push_back(mk(OP_WRITE, {13'($urandom), ADDR_UNLOCK_A},
         {8'($urandom), CMD_ERASE}, '0));
      add_unlock(rnd_addr());
      pending_items.push_back(mk(OP_WRITE, rnd_addr(), {8'($urandom), last_cmd}, '0));
   endtask

   task automatic add_autoselect();
      add_unlock(rnd_addr());
      pending_items.push_back(mk(OP_WRITE, {13'($urandom), ADDR_UNLOCK_A},
         {8'($urandom), CMD_AUTOSEL}, '0));
      foreach (id_offsets[k])
         pending_items.push_back(mk(OP_READ, {16'($urandom), id_offsets[k]}, '0, 16'($urandom)));
      add_reads(2);
      pending_items.push_back(mk(OP_WRITE, rnd_addr(), {8'($urandom), CMD_RESET}, '0));
   endtask

   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      @(negedge clock);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_PROGRAM_TICKS: prog_ticks = val[15:0];
         CSR_ERASE_TICKS: erase_ticks = val;
         CSR_MAKER: id_words[0] = val[15:0];
         CSR_DEV_ONE: id_words[1] = val[15:0];
         CSR_DEV_TWO: id_words[2] = val[15:0];
         default: id_words[3] = val[15:0];
      endcase
   endtask

   // waits until everything sent has been answered and the block settles
   task automatic wait_quiet();
      while (pending_items.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int pick;
      prog_ticks = 100; erase_ticks = 50000;
      id_words = '{16'd1, 16'd8830, 16'd8738, 16'd8705};
      seq_state = SEQ_IDLE; words_wanted = 0; words_held = 0;
      sector_base = '0; page_base = '0; busy_count = '0; toggle = 0; autosel = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: default ids, then short busy counts and extreme ids
      add_autoselect();
      add_reads(1);
      pending_items.push_back(mk(OP_READ, 24'hFFFFFF, 16'hFFFF, 16'hFFFF));
      pending_items.push_back(mk(OP_READ, 24'h000000, 16'h0000, 16'h0000));
      pending_items.push_back(mk(OP_UNUSED, 24'hFFFFFF, 16'hFFFF, 16'hFFFF));
      wait_quiet();
      write_reg(CSR_PROGRAM_TICKS, 24'd0);
      write_reg(CSR_ERASE_TICKS, 24'd3);
      write_reg(CSR_MAKER, 24'hFFFF);
      write_reg(CSR_DEV_ONE, 24'h0000);
      write_reg(CSR_DEV_TWO, 24'hA5A5);
      write_reg(CSR_DEV_THREE, 24'h5A5A);
      add_buffer(1, 0);
      add_buffer(32, 0);
      add_erase(CMD_SECTOR);
      add_reads(3); add_ticks(4); add_reads(2);
      add_buffer(4, 1);
      add_buffer(4, 3);
      add_autoselect();
      // wait out every expected result before moving on
      wait_quiet();

      write_reg(CSR_PROGRAM_TICKS, 24'd5);
      write_reg(CSR_ERASE_TICKS, 24'd8);
      write_reg(CSR_DEV_THREE, 24'h0001);
      for (int n = 0; n < 6; n++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2: add_buffer(int'($urandom_range(1, 8)), ($urandom_range(0, 3) == 0) ?
                                int'($urandom_range(1, 5)) : 0);
            3: add_erase(($urandom_range(0, 3) == 0) ? 8'($urandom) : CMD_SECTOR);
            4: add_autoselect();
            5: add_ticks(int'($urandom_range(1, 10)));
            6: add_reads(int'($urandom_range(1, 4)));
            7: pending_items.push_back(mk(OP_WRITE, rnd_addr(), 16'($urandom), 16'($urandom)));
            8: begin
               add_unlock(rnd_addr());
               pending_items.push_back(mk(OP_WRITE, rnd_addr(), 16'($urandom), '0));
            end
            default: add_buffer(int'($urandom_range(1, 32)), 0);
         endcase
         add_ticks(int'($urandom_range(0, 3)));
      end
      wait_quiet();
      // last part runs without idling
      no_idle = 1;
      write_reg(CSR_PROGRAM_TICKS, 24'hFFFF);
      write_reg(CSR_ERASE_TICKS, 24'hFFFFFF);
      add_buffer(2, 0);
      add_reads(3);
      wait_quiet();

      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
